FILE: sv/dual_sine_oscillator_with_clipper_top_defines.svh
// Assertion macros for the dual sine oscillator with clipper.
`ifndef DUAL_SINE_OSCILLATOR_WITH_CLIPPER_TOP_DEFINES_SVH
`define DUAL_SINE_OSCILLATOR_WITH_CLIPPER_TOP_DEFINES_SVH

// Check a consequence in the same cycle.
`define DSOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define DSOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dsoc_pkg.sv
// Package with types, constants and codes of the dual sine oscillator.
`timescale 1ns / 1ps
package dsoc_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int EXP_TABLE_BITS_DEF  = 10;

    localparam int CV_W    = 16;
    localparam int AUDIO_W = 15;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 28;

    localparam logic [27:0] STEP_BASE_RESET = 28'd6370040;

    localparam logic [31:0] SIN_A  = 32'd1686629713;
    localparam logic [31:0] SIN_B  = 32'd690630741;
    localparam logic [31:0] SIN_C  = 32'd77742852;
    localparam logic [31:0] EXP_K1 = 32'd747109561;
    localparam logic [31:0] EXP_K2 = 32'd241699285;
    localparam logic [31:0] EXP_K3 = 32'd84932978;

    localparam logic [5:0] MUL_STEPS = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd28;

    typedef enum logic [2:0] {
        REG_STEP_BASE   = 3'd0,
        REG_PITCH_KNOB  = 3'd1,
        REG_OCTAVE_AMT  = 3'd2,
        REG_CLIP_KNOB   = 3'd3,
        REG_ANALOG_MODE = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXP1,
        S_EXP2,
        S_EXP3,
        S_STEP_MUL,
        S_STEP_RND,
        S_PHASE,
        S_SIN_X2,
        S_SIN_CX,
        S_SIN_PX2,
        S_SIN_PX,
        S_SIN_END,
        S_MIX_MUL,
        S_MIX_NUM,
        S_DIV,
        S_CLIP,
        S_OUT
    } state_t;

endpackage

FILE: sv/dsoc_cv_if.sv
// Interfaces for the control voltage, audio and configuration channels.
`timescale 1ns / 1ps
interface dsoc_cv_if;
    logic                                valid;
    logic                                ready;
    logic signed [dsoc_pkg::CV_W-1:0]    pitch_cv;
    logic signed [dsoc_pkg::CV_W-1:0]    shape_cv;
    logic signed [dsoc_pkg::CV_W-1:0]    clip_cv;
    modport source (output valid, pitch_cv, shape_cv, clip_cv, input ready);
    modport sink (input valid, pitch_cv, shape_cv, clip_cv, output ready);
endinterface

interface dsoc_audio_if;
    logic                                valid;
    logic                                ready;
    logic signed [dsoc_pkg::AUDIO_W-1:0] audio_out;
    modport source (output valid, audio_out, input ready);
    modport sink (input valid, audio_out, output ready);
endinterface

interface dsoc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dsoc_pkg::IDX_W-1:0]          index;
    logic [dsoc_pkg::DATA_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dual_sine_oscillator_with_clipper_top.sv
// Top level of the dual sine oscillator with clipper.
`timescale 1ns / 1ps
`include "dual_sine_oscillator_with_clipper_top_defines.svh"
// One transaction on cv produces one audio sample on audio. The block works on
// one sample at a time and accepts the next transaction only after the sample
// is taken. The work is done by one shared radix-2 shift-and-add multiplier
// (17 products: three for 2^f, one for the step scaling, four per sine for
// three sines, one for the sub-octave mix) and a restoring divider for the
// mix normalization. Configuration writes are taken in any cycle and
// must only occur while the block is idle.
module dual_sine_oscillator_with_clipper_top #(
    parameter int SINE_TABLE_BITS = dsoc_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = dsoc_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dsoc_cv_if.sink       cv,
    dsoc_audio_if.source  audio,
    dsoc_cfg_if.sink      cfg
);

    dsoc_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [27:0]        step_base_reg;
    logic signed [13:0] pitch_knob_reg;
    logic [11:0]        octave_amt_reg;
    logic [13:0]        clip_knob_reg;
    logic               analog_mode_reg;

    logic [31:0] phase_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  k_reg;

    // Payload registers.
    logic [63:0]        prod_reg;
    logic [31:0]        mcand_reg;
    logic [31:0]        x_reg;
    logic [31:0]        x2_reg;
    logic [11:0]        a_reg;
    logic [13:0]        thr_reg;
    logic signed [3:0]  oct_reg;
    logic signed [15:0] s2_reg, s1_reg, s5_reg;
    logic [15:0]        d_reg;
    logic [15:0]        rem_reg;
    logic [28:0]        quo_reg;
    logic               neg_reg;
    logic signed [14:0] out_reg;

    logic in_fire, out_fire, mul_state, mul_done, div_done;

    assign in_fire  = cv.valid && cv.ready;
    assign out_fire = audio.valid && audio.ready;
    assign mul_done = cnt_reg == dsoc_pkg::MUL_STEPS;
    assign div_done = cnt_reg == dsoc_pkg::DIV_LAST;

    always_comb
    begin
        case (state_reg)
            dsoc_pkg::S_EXP1, dsoc_pkg::S_EXP2, dsoc_pkg::S_EXP3, dsoc_pkg::S_STEP_MUL,
            dsoc_pkg::S_SIN_X2, dsoc_pkg::S_SIN_CX, dsoc_pkg::S_SIN_PX2, dsoc_pkg::S_SIN_PX,
            dsoc_pkg::S_MIX_MUL: mul_state = 1'b1;
            default:             mul_state = 1'b0;
        endcase
    end

    // Clamp the control sums on acceptance.
    logic signed [16:0] pitch_sum;
    logic signed [16:0] a_sum;
    logic signed [17:0] thr_sum;
    logic signed [14:0] pitch_c;
    logic [11:0]        a_c;
    logic [13:0]        thr_c;
    logic [15:0]        fq;

    always_comb
    begin
        pitch_sum = 17'({{3{pitch_knob_reg[13]}}, pitch_knob_reg}) +
                    17'({cv.pitch_cv[15], cv.pitch_cv});
        a_sum     = $signed({5'b00000, octave_amt_reg}) + 17'({cv.shape_cv[15], cv.shape_cv});
        thr_sum   = 18'sd10240 - $signed({4'b0000, clip_knob_reg}) +
                    18'({{2{cv.clip_cv[15]}}, cv.clip_cv});
        if (pitch_sum < -17'sd8192)
            pitch_c = -15'sd8192;
        else if (pitch_sum > 17'sd8192)
            pitch_c = 15'sd8192;
        else
            pitch_c = pitch_sum[14:0];
        if (a_sum < 17'sd0)
            a_c = 12'd0;
        else if (a_sum > 17'sd2048)
            a_c = 12'd2048;
        else
            a_c = a_sum[11:0];
        if (thr_sum < 18'sd0)
            thr_c = 14'd0;
        else if (thr_sum > 18'sd10240)
            thr_c = 14'd10240;
        else
            thr_c = thr_sum[13:0];
        // Truncate the fraction to the 2^f table resolution.
        fq = {pitch_c[10:0], 5'b00000};
        fq = {fq[15 -: EXP_TABLE_BITS], {(16 - EXP_TABLE_BITS){1'b0}}};
    end

    // Phase of the sine being formed: full rate, half rate and five times the half rate.
    logic [31:0] t_half, t_fifth, t_sel, t_q;
    logic [1:0]  quad;
    logic [30:0] sin_x;

    always_comb
    begin
        t_half  = {phase_reg[31], phase_reg[31:1]};
        t_fifth = t_half + {t_half[29:0], 2'b00};
        case (k_reg)
            2'd0:    t_sel = phase_reg;
            2'd1:    t_sel = t_half;
            default: t_sel = t_fifth;
        endcase
        t_q   = {t_sel[31 -: SINE_TABLE_BITS], {(32 - SINE_TABLE_BITS){1'b0}}};
        quad  = t_q[31:30];
        sin_x = quad[0] ? (31'h40000000 - {1'b0, t_q[29:0]}) : {1'b0, t_q[29:0]};
    end

    // Operands loaded into the multiplier at the start of each product.
    logic [31:0] q30, ld_mcand, ld_mplier;

    assign q30 = prod_reg[61:30];

    always_comb
    begin
        ld_mcand  = '0;
        ld_mplier = '0;
        case (state_reg)
            dsoc_pkg::S_EXP1:
            begin
                ld_mcand  = dsoc_pkg::EXP_K3;
                ld_mplier = x_reg;
            end
            dsoc_pkg::S_EXP2:
            begin
                ld_mcand  = dsoc_pkg::EXP_K2 + q30;
                ld_mplier = x_reg;
            end
            dsoc_pkg::S_EXP3:
            begin
                ld_mcand  = dsoc_pkg::EXP_K1 + q30;
                ld_mplier = x_reg;
            end
            dsoc_pkg::S_STEP_MUL:
            begin
                ld_mcand  = {4'b0000, step_base_reg};
                ld_mplier = 32'h40000000 + q30;
            end
            dsoc_pkg::S_SIN_X2:
            begin
                ld_mcand  = {1'b0, sin_x};
                ld_mplier = {1'b0, sin_x};
            end
            dsoc_pkg::S_SIN_CX:
            begin
                ld_mcand  = dsoc_pkg::SIN_C;
                ld_mplier = q30;
            end
            dsoc_pkg::S_SIN_PX2:
            begin
                ld_mcand  = dsoc_pkg::SIN_B - q30;
                ld_mplier = x2_reg;
            end
            dsoc_pkg::S_SIN_PX:
            begin
                ld_mcand  = dsoc_pkg::SIN_A - q30;
                ld_mplier = x_reg;
            end
            dsoc_pkg::S_MIX_MUL:
            begin
                ld_mcand  = 32'(s1_reg[15] ? -s1_reg : s1_reg);
                ld_mplier = {20'd0, a_reg};
            end
            default:
            begin
                ld_mcand  = '0;
                ld_mplier = '0;
            end
        endcase
    end

    // Datapath terms of the multiplier, rounding, sine, divider and clip steps.
    logic [32:0]        mul_sum;
    logic [5:0]         shamt;
    logic [63:0]        step_full;
    logic [32:0]        y_rnd;
    logic [15:0]        s_mag;
    logic signed [15:0] s_new;
    logic signed [27:0] sprod, num;
    logic signed [30:0] n5;
    logic [28:0]        absn;
    logic [15:0]        d_new;
    logic [16:0]        trial;
    logic               ge;
    logic [14:0]        q_mag, w_mag, ceil_mag, v_mag;
    logic               clip;

    always_comb
    begin
        mul_sum   = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, mcand_reg} : 33'd0);
        shamt     = 6'(7'sd30 - 7'(oct_reg));
        step_full = prod_reg >> shamt;
        y_rnd     = {1'b0, q30} + 33'd32768;
        s_mag     = y_rnd[31:16];
        s_new     = quad[1] ? -$signed(s_mag) : $signed(s_mag);
        sprod     = s1_reg[15] ? -$signed(prod_reg[27:0]) : $signed(prod_reg[27:0]);
        num       = {s2_reg[15], s2_reg, 11'd0} + sprod;
        // Times five as the sum of the term and four times the term.
        n5        = {{3{num[27]}}, num} + {num[27], num, 2'b00};
        absn      = n5[30] ? 29'(-n5) : n5[28:0];
        d_new     = {4'b0000, a_reg} + 16'd2048;
        d_new     = {d_new[12:0], 3'b000};
        trial     = {rem_reg, quo_reg[28]};
        ge        = trial >= {1'b0, d_reg};
        q_mag     = quo_reg[14:0];
        w_mag     = 15'((s5_reg[15] ? -s5_reg : s5_reg) + 16'sd8) >> 4;
        if (analog_mode_reg)
            ceil_mag = 15'd10240;
        else if (s5_reg[15])
            ceil_mag = 15'd10240 - w_mag;
        else
            ceil_mag = 15'd10240 + w_mag;
        clip      = (q_mag >= {1'b0, thr_reg}) && (q_mag != 15'd0);
        v_mag     = clip ? ceil_mag : q_mag;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsoc_pkg::S_IDLE:     if (in_fire) state_next = dsoc_pkg::S_EXP1;
            dsoc_pkg::S_EXP1:     if (mul_done) state_next = dsoc_pkg::S_EXP2;
            dsoc_pkg::S_EXP2:     if (mul_done) state_next = dsoc_pkg::S_EXP3;
            dsoc_pkg::S_EXP3:     if (mul_done) state_next = dsoc_pkg::S_STEP_MUL;
            dsoc_pkg::S_STEP_MUL: if (mul_done) state_next = dsoc_pkg::S_STEP_RND;
            dsoc_pkg::S_STEP_RND: state_next = dsoc_pkg::S_PHASE;
            dsoc_pkg::S_PHASE:    state_next = dsoc_pkg::S_SIN_X2;
            dsoc_pkg::S_SIN_X2:   if (mul_done) state_next = dsoc_pkg::S_SIN_CX;
            dsoc_pkg::S_SIN_CX:   if (mul_done) state_next = dsoc_pkg::S_SIN_PX2;
            dsoc_pkg::S_SIN_PX2:  if (mul_done) state_next = dsoc_pkg::S_SIN_PX;
            dsoc_pkg::S_SIN_PX:   if (mul_done) state_next = dsoc_pkg::S_SIN_END;
            dsoc_pkg::S_SIN_END:
                state_next = (k_reg == 2'd2) ? dsoc_pkg::S_MIX_MUL : dsoc_pkg::S_SIN_X2;
            dsoc_pkg::S_MIX_MUL:  if (mul_done) state_next = dsoc_pkg::S_MIX_NUM;
            dsoc_pkg::S_MIX_NUM:  state_next = dsoc_pkg::S_DIV;
            dsoc_pkg::S_DIV:      if (div_done) state_next = dsoc_pkg::S_CLIP;
            dsoc_pkg::S_CLIP:     state_next = dsoc_pkg::S_OUT;
            dsoc_pkg::S_OUT:      if (out_fire) state_next = dsoc_pkg::S_IDLE;
            default:              state_next = dsoc_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        cv.ready        = state_reg == dsoc_pkg::S_IDLE;
        audio.valid     = state_reg == dsoc_pkg::S_OUT;
        audio.audio_out = out_reg;
        cfg.ready       = 1'b1;
    end

    // Control state, configuration and phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dsoc_pkg::S_IDLE;
            cnt_reg         <= '0;
            k_reg           <= '0;
            phase_reg       <= '0;
            step_base_reg   <= dsoc_pkg::STEP_BASE_RESET;
            pitch_knob_reg  <= '0;
            octave_amt_reg  <= '0;
            clip_knob_reg   <= '0;
            analog_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Count product and quotient bits; clear between units.
            if (mul_state)
                cnt_reg <= mul_done ? 6'd0 : cnt_reg + 6'd1;
            else if (state_reg == dsoc_pkg::S_DIV)
                cnt_reg <= div_done ? 6'd0 : cnt_reg + 6'd1;
            else
                cnt_reg <= 6'd0;
            if (state_reg == dsoc_pkg::S_PHASE)
            begin
                phase_reg <= phase_reg + step_full[31:0];
                k_reg     <= 2'd0;
            end
            else if (state_reg == dsoc_pkg::S_SIN_END)
                k_reg <= k_reg + 2'd1;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    dsoc_pkg::REG_STEP_BASE:   step_base_reg   <= cfg.data;
                    dsoc_pkg::REG_PITCH_KNOB:  pitch_knob_reg  <= cfg.data[13:0];
                    dsoc_pkg::REG_OCTAVE_AMT:  octave_amt_reg  <= cfg.data[11:0];
                    dsoc_pkg::REG_CLIP_KNOB:   clip_knob_reg   <= cfg.data[13:0];
                    dsoc_pkg::REG_ANALOG_MODE: analog_mode_reg <= cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload: multiplier, sine terms, divider and result.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg   <= a_c;
            thr_reg <= thr_c;
            oct_reg <= pitch_c[14:11];
            x_reg   <= {2'b00, fq, 14'd0};
        end
        if (mul_state)
        begin
            if (cnt_reg == 6'd0)
            begin
                // Load operands; capture the sine argument, or the square the previous product left.
                mcand_reg <= ld_mcand;
                prod_reg  <= {32'd0, ld_mplier};
                if (state_reg == dsoc_pkg::S_SIN_X2)
                    x_reg <= {1'b0, sin_x};
                if (state_reg == dsoc_pkg::S_SIN_CX)
                    x2_reg <= q30;
            end
            else
                prod_reg <= {mul_sum, prod_reg[31:1]};
        end
        if (state_reg == dsoc_pkg::S_STEP_RND)
            prod_reg <= prod_reg + (64'd1 << (shamt - 6'd1));
        if (state_reg == dsoc_pkg::S_SIN_END)
        begin
            case (k_reg)
                2'd0:    s2_reg <= s_new;
                2'd1:    s1_reg <= s_new;
                default: s5_reg <= s_new;
            endcase
        end
        if (state_reg == dsoc_pkg::S_MIX_NUM)
        begin
            neg_reg <= n5[30];
            d_reg   <= d_new;
            rem_reg <= '0;
            quo_reg <= absn + 29'({d_new[15:1]});
        end
        if (state_reg == dsoc_pkg::S_DIV)
        begin
            rem_reg <= ge ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            quo_reg <= {quo_reg[27:0], ge};
        end
        if (state_reg == dsoc_pkg::S_CLIP)
            out_reg <= neg_reg ? -$signed(v_mag) : $signed(v_mag);
    end

    // Take a new sample only from idle.
    `DSOC_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, state_reg == dsoc_pkg::S_EXP1, "accept did not start the sequence")
    // Never offer a result and take a sample together.
    `DSOC_ASSERT_NOW(a_one_at_a_time, clk, rst_n, audio.valid, !cv.ready, "input ready while result pending")
    // Advance the phase only in its own step.
    `DSOC_ASSERT_NEXT(a_phase_hold, clk, rst_n, state_reg != dsoc_pkg::S_PHASE, phase_reg == $past(phase_reg), "phase moved outside its step")

endmodule
